>>> rtl/fbc_pkg.sv
// ============================================================================
// fbc_pkg - shared definitions for the frustum box classifier
// Constants for the register map, the plane chain and the verdict codes.
// ============================================================================
package fbc_pkg;

    // Default field widths
    localparam int COORD_WIDTH_DEF  = 24;
    localparam int MATRIX_WIDTH_DEF = 32;

    // Geometry
    localparam int NUM_PLANES     = 6;
    localparam int NUM_AXES       = 3;
    localparam int MATRIX_DIM     = 4;
    localparam int PLANES_PER_ROW = 2;      // row 3 plus and minus one side row
    localparam int OFFSET_SHIFT   = 8;      // plane offset Q.16 -> Q.24

    // Register map: one 64-bit register per column pair of rows, at 8*i
    localparam int CFG_NUM_REGS     = 8;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_SLOT_W       = 32;
    localparam int CFG_ROWS_PER_REG = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_IDX_LSB      = 3;
    localparam int CFG_ADDR_W       = CFG_IDX_W + CFG_IDX_LSB;

    // Result codes
    typedef enum logic [1:0] {
        VERDICT_INSIDE  = 2'd0,
        VERDICT_PARTIAL = 2'd1,
        VERDICT_OUTSIDE = 2'd2
    } verdict_t;

    // Running plane test flags carried along the chain
    typedef struct packed {
        logic outside;
        logic partial;
    } fbc_flags_t;

endpackage

>>> rtl/fbc_cfg_regs.sv
// ============================================================================
// fbc_cfg_regs - clip matrix register file
// Eight 64-bit APB registers; presents the matrix as sixteen signed entries.
// ============================================================================
module fbc_cfg_regs #(
    parameter int MATRIX_WIDTH = fbc_pkg::MATRIX_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fbc_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [fbc_pkg::CFG_DATA_W-1:0]         prdata,
    output logic [fbc_pkg::MATRIX_DIM-1:0][fbc_pkg::MATRIX_DIM-1:0][MATRIX_WIDTH-1:0] matrix
);

    logic [fbc_pkg::CFG_DATA_W-1:0] clip_reg [fbc_pkg::CFG_NUM_REGS];
    logic [fbc_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[fbc_pkg::CFG_ADDR_W-1:fbc_pkg::CFG_IDX_LSB];
    assign wr_en   = psel && penable && pwrite;

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fbc_pkg::CFG_NUM_REGS; i++)
            begin
                clip_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            clip_reg[reg_idx] <= pwdata;
        end
    end

    // Read back
    assign prdata = clip_reg[reg_idx];

    // Unpack entries: column c, rows r and r+1 share a register, lower row low
    for (genvar r = 0; r < fbc_pkg::MATRIX_DIM; r++)
    begin : g_row
        for (genvar c = 0; c < fbc_pkg::MATRIX_DIM; c++)
        begin : g_col
            localparam int RegIdx  = c * fbc_pkg::CFG_ROWS_PER_REG
                                     + r / fbc_pkg::CFG_ROWS_PER_REG;
            localparam int SlotLsb = fbc_pkg::CFG_SLOT_W * (r % fbc_pkg::CFG_ROWS_PER_REG);
            assign matrix[r][c] = clip_reg[RegIdx][SlotLsb +: MATRIX_WIDTH];
        end
    end

endmodule

>>> rtl/fbc_plane_cell.sv
// ============================================================================
// fbc_plane_cell - one frustum plane test
// Three-stage cell: products, distance/reach sums, far and near vertex signs.
// ============================================================================
module fbc_plane_cell #(
    parameter int COORD_WIDTH  = fbc_pkg::COORD_WIDTH_DEF,
    parameter int MATRIX_WIDTH = fbc_pkg::MATRIX_WIDTH_DEF,
    parameter bit MINUS        = 1'b0
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic [fbc_pkg::MATRIX_DIM-1:0][MATRIX_WIDTH-1:0]     base_row,
    input  logic [fbc_pkg::MATRIX_DIM-1:0][MATRIX_WIDTH-1:0]     side_row,
    input  logic                                                 up_valid,
    output logic                                                 up_ready,
    input  logic [fbc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]        up_center,
    input  logic [fbc_pkg::NUM_AXES-1:0][COORD_WIDTH-2:0]        up_half,
    input  fbc_pkg::fbc_flags_t                                  up_flags,
    output logic                                                 dn_valid,
    input  logic                                                 dn_ready,
    output logic [fbc_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]        dn_center,
    output logic [fbc_pkg::NUM_AXES-1:0][COORD_WIDTH-2:0]        dn_half,
    output fbc_pkg::fbc_flags_t                                  dn_flags
);

    localparam int NA         = fbc_pkg::NUM_AXES;
    localparam int CW         = COORD_WIDTH;
    localparam int HW         = COORD_WIDTH - 1;
    localparam int PW         = MATRIX_WIDTH + 1;   // plane coefficient
    localparam int PCW        = PW + CW;            // coefficient * centre
    localparam int PHW        = PW + HW;            // |coefficient| * half
    localparam int DW         = PCW + 2;            // distance sum
    localparam int RW         = PHW + 2;            // reach sum
    localparam int SW         = DW + 1;             // distance +/- reach
    localparam int OFFSET_COL = fbc_pkg::MATRIX_DIM - 1;

    // ------------------------------------------------------------------
    // Plane coefficients, refreshed from the matrix every cycle
    // ------------------------------------------------------------------
    logic signed [PW-1:0] coef_next [fbc_pkg::MATRIX_DIM];
    logic signed [PW-1:0] coef_reg  [fbc_pkg::MATRIX_DIM];
    logic        [PW-1:0] mag_next  [NA];
    logic        [PW-1:0] mag_reg   [NA];

    always_comb
    begin
        for (int j = 0; j < fbc_pkg::MATRIX_DIM; j++)
        begin
            if (MINUS)
                coef_next[j] = PW'($signed(base_row[j])) - PW'($signed(side_row[j]));
            else
                coef_next[j] = PW'($signed(base_row[j])) + PW'($signed(side_row[j]));
        end
        for (int j = 0; j < NA; j++)
        begin
            mag_next[j] = coef_next[j][PW-1] ? PW'(-coef_next[j]) : PW'(coef_next[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < fbc_pkg::MATRIX_DIM; j++)
        begin
            coef_reg[j] <= coef_next[j];
        end
        for (int j = 0; j < NA; j++)
        begin
            mag_reg[j] <= mag_next[j];
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage moves when the next is empty or moving
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_adv, s2_adv, s3_adv;

    assign s3_adv   = !s3_valid_reg || dn_ready;
    assign s2_adv   = !s2_valid_reg || s3_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign up_ready = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= up_valid;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (s3_adv)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: per-axis products
    // ------------------------------------------------------------------
    logic signed [PCW-1:0] pc_next [NA];
    logic        [PHW-1:0] ph_next [NA];
    logic signed [PCW-1:0] pc_reg  [NA];
    logic        [PHW-1:0] ph_reg  [NA];
    logic [NA-1:0][CW-1:0] center_s1_reg;
    logic [NA-1:0][HW-1:0] half_s1_reg;
    fbc_pkg::fbc_flags_t   flags_s1_reg;

    always_comb
    begin
        for (int j = 0; j < NA; j++)
        begin
            pc_next[j] = PCW'(coef_reg[j]) * PCW'($signed(up_center[j]));
            ph_next[j] = PHW'(mag_reg[j]) * PHW'(up_half[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            for (int j = 0; j < NA; j++)
            begin
                pc_reg[j] <= pc_next[j];
                ph_reg[j] <= ph_next[j];
            end
            center_s1_reg <= up_center;
            half_s1_reg   <= up_half;
            flags_s1_reg  <= up_flags;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: centre distance and half-extent reach
    // ------------------------------------------------------------------
    logic signed [DW-1:0]  dist_next, dist_reg;
    logic        [RW-1:0]  reach_next, reach_reg;
    logic [NA-1:0][CW-1:0] center_s2_reg;
    logic [NA-1:0][HW-1:0] half_s2_reg;
    fbc_pkg::fbc_flags_t   flags_s2_reg;

    assign dist_next = DW'($signed({coef_reg[OFFSET_COL], {fbc_pkg::OFFSET_SHIFT{1'b0}}}))
                     + DW'(pc_reg[0]) + DW'(pc_reg[1]) + DW'(pc_reg[2]);
    assign reach_next = RW'(ph_reg[0]) + RW'(ph_reg[1]) + RW'(ph_reg[2]);

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            dist_reg      <= dist_next;
            reach_reg     <= reach_next;
            center_s2_reg <= center_s1_reg;
            half_s2_reg   <= half_s1_reg;
            flags_s2_reg  <= flags_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: far vertex behind -> outside, near vertex behind -> partial
    // ------------------------------------------------------------------
    logic signed [SW-1:0]  far_dist, near_dist;
    fbc_pkg::fbc_flags_t   flags_next, flags_s3_reg;
    logic [NA-1:0][CW-1:0] center_s3_reg;
    logic [NA-1:0][HW-1:0] half_s3_reg;

    always_comb
    begin
        far_dist           = SW'(dist_reg) + SW'($signed({1'b0, reach_reg}));
        near_dist          = SW'(dist_reg) - SW'($signed({1'b0, reach_reg}));
        flags_next.outside = flags_s2_reg.outside | far_dist[SW-1];
        flags_next.partial = flags_s2_reg.partial | near_dist[SW-1];
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            flags_s3_reg  <= flags_next;
            center_s3_reg <= center_s2_reg;
            half_s3_reg   <= half_s2_reg;
        end
    end

    assign dn_valid  = s3_valid_reg;
    assign dn_center = center_s3_reg;
    assign dn_half   = half_s3_reg;
    assign dn_flags  = flags_s3_reg;

endmodule

>>> rtl/frustum_box_classifier_core.sv
// ============================================================================
// frustum_box_classifier_core - box against view frustum classifier
// Six plane cells in a chain test each box against the clip-matrix planes.
// ============================================================================
//
//  Channel   Handshake                      Payload
//  --------  -----------------------------  ------------------------------------
//  box       box_valid / box_ready          center_x/y/z, half_x/y/z
//  verdict   verdict_valid / verdict_ready  verdict (0 inside, 1 partial, 2 out)
//  config    APB psel/penable, pready = 1   paddr, pwdata, prdata (8 x 64 bit)
//
//  One box per cycle sustained while verdicts are taken; a verdict passes the
//  input register, six plane cells of three stages each and output register.
//  Each cell has one multiplier stage for all axes; that stage sets the clock.
//  Reset clears all valid flags and the clip matrix to zero.
//  Every stage holds only while the one after it is full and stalled, so
//  empty slots close up and boxes are taken while a verdict waits.
//  A matrix write reaches the planes through each cell's coefficient registers.
// ============================================================================
module frustum_box_classifier_core #(
    parameter int COORD_WIDTH  = fbc_pkg::COORD_WIDTH_DEF,
    parameter int MATRIX_WIDTH = fbc_pkg::MATRIX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fbc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fbc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    // boxes
    input  logic                               box_valid,
    output logic                               box_ready,
    input  logic signed [COORD_WIDTH-1:0]      center_x,
    input  logic signed [COORD_WIDTH-1:0]      center_y,
    input  logic signed [COORD_WIDTH-1:0]      center_z,
    input  logic [COORD_WIDTH-2:0]             half_x,
    input  logic [COORD_WIDTH-2:0]             half_y,
    input  logic [COORD_WIDTH-2:0]             half_z,
    // verdicts
    output logic                               verdict_valid,
    input  logic                               verdict_ready,
    output logic [1:0]                         verdict
);

    localparam int NP = fbc_pkg::NUM_PLANES;
    localparam int NA = fbc_pkg::NUM_AXES;
    localparam int CW = COORD_WIDTH;
    localparam int HW = COORD_WIDTH - 1;

    logic [fbc_pkg::MATRIX_DIM-1:0][fbc_pkg::MATRIX_DIM-1:0][MATRIX_WIDTH-1:0] matrix;

    // Register file
    assign pready = 1'b1;

    fbc_cfg_regs #(
        .MATRIX_WIDTH (MATRIX_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .matrix  (matrix)
    );

    // Links between cells
    logic [NP:0]                     link_valid;
    logic [NP:0]                     link_ready;
    logic [NP:0][NA-1:0][CW-1:0]     link_center;
    logic [NP:0][NA-1:0][HW-1:0]     link_half;
    fbc_pkg::fbc_flags_t [NP:0]      link_flags;

    // Input register
    logic                  box_valid_reg;
    logic                  box_adv;
    logic [NA-1:0][CW-1:0] center_reg;
    logic [NA-1:0][HW-1:0] half_reg;

    assign box_adv   = !box_valid_reg || link_ready[0];
    assign box_ready = box_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_valid_reg <= 1'b0;
        else if (box_adv)
            box_valid_reg <= box_valid;
    end

    always_ff @(posedge clk)
    begin
        if (box_adv)
        begin
            center_reg <= {center_z, center_y, center_x};
            half_reg   <= {half_z, half_y, half_x};
        end
    end

    assign link_valid[0]  = box_valid_reg;
    assign link_center[0] = center_reg;
    assign link_half[0]   = half_reg;
    assign link_flags[0]  = '0;

    // Plane cells: row 3 plus, then minus, each of rows 0..2
    for (genvar k = 0; k < NP; k++)
    begin : g_cell
        localparam int SideRow = k / fbc_pkg::PLANES_PER_ROW;
        localparam bit Minus   = (k % fbc_pkg::PLANES_PER_ROW) != 0;

        fbc_plane_cell #(
            .COORD_WIDTH  (COORD_WIDTH),
            .MATRIX_WIDTH (MATRIX_WIDTH),
            .MINUS        (Minus)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .base_row  (matrix[fbc_pkg::MATRIX_DIM-1]),
            .side_row  (matrix[SideRow]),
            .up_valid  (link_valid[k]),
            .up_ready  (link_ready[k]),
            .up_center (link_center[k]),
            .up_half   (link_half[k]),
            .up_flags  (link_flags[k]),
            .dn_valid  (link_valid[k+1]),
            .dn_ready  (link_ready[k+1]),
            .dn_center (link_center[k+1]),
            .dn_half   (link_half[k+1]),
            .dn_flags  (link_flags[k+1])
        );
    end

    // Output register
    logic               verdict_valid_reg;
    logic               out_adv;
    fbc_pkg::verdict_t  verdict_next, verdict_reg;

    assign out_adv        = !verdict_valid_reg || verdict_ready;
    assign link_ready[NP] = out_adv;

    always_comb
    begin
        if (link_flags[NP].outside)
            verdict_next = fbc_pkg::VERDICT_OUTSIDE;
        else if (link_flags[NP].partial)
            verdict_next = fbc_pkg::VERDICT_PARTIAL;
        else
            verdict_next = fbc_pkg::VERDICT_INSIDE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            verdict_valid_reg <= 1'b0;
        else if (out_adv)
            verdict_valid_reg <= link_valid[NP];
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
            verdict_reg <= verdict_next;
    end

    assign verdict_valid = verdict_valid_reg;
    assign verdict       = verdict_reg;

endmodule

>>> tb/sv/frustum_box_classifier_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// frustum_box_classifier_core_tb - self-checking bench for the box classifier
// Loads clip matrices over APB and streams boxes through the valid/ready
// channels. The sender works in bursts and the sink stalls on a pattern of
// its own. Each verdict is compared with a local plane-test predictor or, for the
// first rows of the directed table, with a verdict that is known by hand.
// ============================================================================
module frustum_box_classifier_core_tb;

    localparam int  CW          = fbc_pkg::COORD_WIDTH_DEF;
    localparam time CLK_PERIOD  = 10ns;
    localparam int  HOLD_CYCLES = 300;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN       = 30;
    localparam int  ONE         = 1 << 16;     // 1.0 in Q16.16

    typedef logic signed [CW-1:0]             coord_t;
    typedef logic [CW-2:0]                    extent_t;
    typedef logic [fbc_pkg::CFG_ADDR_W-1:0]   paddr_t;
    typedef logic [fbc_pkg::CFG_DATA_W-1:0]   cfg_word_t;

    localparam coord_t  C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t  C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam extent_t H_MAX = '1;

    typedef enum int {
        MAT_ZERO, MAT_UNIT, MAT_SKEW, MAT_MAX_MIN, MAT_ALL_ONES, MAT_FRUSTUM, MAT_NOISE
    } mat_kind_t;

    typedef enum int { SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE } sink_mode_t;

    typedef struct {
        mat_kind_t         mat;
        coord_t            cx, cy, cz;
        extent_t           hx, hy, hz;
        bit                known;
        fbc_pkg::verdict_t want;
    } box_row_t;

    // Clock, reset and block inputs, all known from time zero
    logic      clk           = 1'b0;
    logic      rst_n         = 1'b0;
    logic      psel          = 1'b0;
    logic      penable       = 1'b0;
    logic      pwrite        = 1'b0;
    paddr_t    paddr         = '0;
    cfg_word_t pwdata        = '0;
    cfg_word_t prdata;
    logic      pready;
    logic      box_valid     = 1'b0;
    logic      box_ready;
    coord_t    center_x      = '0;
    coord_t    center_y      = '0;
    coord_t    center_z      = '0;
    extent_t   half_x        = '0;
    extent_t   half_y        = '0;
    extent_t   half_z        = '0;
    logic      verdict_valid;
    logic      verdict_ready = 1'b0;
    logic [1:0] verdict;

    // Bench state
    cfg_word_t         clip_regs [fbc_pkg::CFG_NUM_REGS];
    int                mat_q [fbc_pkg::MATRIX_DIM][fbc_pkg::MATRIX_DIM];
    fbc_pkg::verdict_t pending_verdicts [$];
    int                error_count   = 0;
    int                cycle_count   = 0;
    int                burst_left    = 10;
    int                hold_requests = 0;
    int                holds_served  = 0;

    // Directed boxes; unit matrix keeps the frustum at |x|,|y|,|z| <= 1.0 (256)
    box_row_t directed [22] = '{
        '{MAT_ZERO, 0,     0,     0,     0,     0,     0,     1, fbc_pkg::VERDICT_INSIDE},
        '{MAT_ZERO, C_MAX, C_MIN, -1,    H_MAX, H_MAX, H_MAX, 1, fbc_pkg::VERDICT_INSIDE},
        '{MAT_ZERO, C_MIN, C_MAX, 0,     0,     0,     0,     1, fbc_pkg::VERDICT_INSIDE},
        '{MAT_UNIT, 0,     0,     0,     0,     0,     0,     1, fbc_pkg::VERDICT_INSIDE},
        '{MAT_UNIT, 0,     0,     0,     128,   128,   128,   1, fbc_pkg::VERDICT_INSIDE},
        '{MAT_UNIT, 256,   0,     0,     0,     0,     0,     1, fbc_pkg::VERDICT_INSIDE},
        '{MAT_UNIT, 0,     0,     0,     256,   0,     0,     1, fbc_pkg::VERDICT_INSIDE},
        '{MAT_UNIT, 257,   0,     0,     0,     0,     0,     1, fbc_pkg::VERDICT_OUTSIDE},
        '{MAT_UNIT, -257,  0,     0,     0,     0,     0,     1, fbc_pkg::VERDICT_OUTSIDE},
        '{MAT_UNIT, 0,     300,   0,     0,     0,     0,     1, fbc_pkg::VERDICT_OUTSIDE},
        '{MAT_UNIT, 0,     0,     -300,  0,     0,     0,     1, fbc_pkg::VERDICT_OUTSIDE},
        '{MAT_UNIT, 0,     0,     0,     512,   0,     0,     1, fbc_pkg::VERDICT_PARTIAL},
        '{MAT_UNIT, 0,     0,     C_MAX, 0,     0,     0,     1, fbc_pkg::VERDICT_OUTSIDE},
        '{MAT_UNIT, C_MIN, 0,     0,     0,     0,     0,     1, fbc_pkg::VERDICT_OUTSIDE},
        '{MAT_UNIT, 0,     0,     0,     H_MAX, H_MAX, H_MAX, 1, fbc_pkg::VERDICT_PARTIAL},
        '{MAT_UNIT, 200,   0,     0,     100,   0,     0,     1, fbc_pkg::VERDICT_PARTIAL},
        '{MAT_UNIT, -400,  0,     0,     100,   0,     0,     1, fbc_pkg::VERDICT_OUTSIDE},
        '{MAT_UNIT, -300,  0,     0,     44,    0,     0,     1, fbc_pkg::VERDICT_PARTIAL},
        '{MAT_SKEW, 0,     0,     0,     0,     0,     0,     0, fbc_pkg::VERDICT_INSIDE},
        '{MAT_SKEW, C_MAX, C_MAX, C_MIN, H_MAX, H_MAX, H_MAX, 0, fbc_pkg::VERDICT_INSIDE},
        '{MAT_SKEW, -180,  C_MIN, 90,    60,    H_MAX, 30,    0, fbc_pkg::VERDICT_INSIDE},
        '{MAT_SKEW, 40,    C_MAX, -20,   10,    H_MAX, 5,     0, fbc_pkg::VERDICT_INSIDE}
    };

    // Random phases: matrix kind and number of boxes under it
    mat_kind_t random_kinds  [7] = '{MAT_MAX_MIN, MAT_FRUSTUM, MAT_ALL_ONES, MAT_FRUSTUM,
                                     MAT_NOISE, MAT_FRUSTUM, MAT_ZERO};
    int        random_counts [7] = '{40, 150, 40, 150, 100, 150, 40};

    frustum_box_classifier_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .box_valid     (box_valid),
        .box_ready     (box_ready),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .half_x        (half_x),
        .half_y        (half_y),
        .half_z        (half_z),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict       (verdict)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Clip matrix entry, row r column c, from the mirrored registers
    function automatic longint clip_entry(int r, int c);
        cfg_word_t word;
        word = clip_regs[c * fbc_pkg::CFG_ROWS_PER_REG + r / fbc_pkg::CFG_ROWS_PER_REG];
        if (r % fbc_pkg::CFG_ROWS_PER_REG != 0)
            return longint'(signed'(word[2*fbc_pkg::CFG_SLOT_W-1:fbc_pkg::CFG_SLOT_W]));
        return longint'(signed'(word[fbc_pkg::CFG_SLOT_W-1:0]));
    endfunction

    // Plane test: far vertex behind any plane is outside, near vertex behind is partial
    function automatic fbc_pkg::verdict_t classify_box(coord_t cx, coord_t cy, coord_t cz,
                                                       extent_t hx, extent_t hy, extent_t hz);
        longint ctr [fbc_pkg::NUM_AXES];
        longint ext [fbc_pkg::NUM_AXES];
        longint plane [fbc_pkg::MATRIX_DIM];
        longint plane_dist;
        longint reach;
        bit     partial;
        int     row;
        ctr[0] = cx;  ctr[1] = cy;  ctr[2] = cz;
        ext[0] = hx;  ext[1] = hy;  ext[2] = hz;
        partial = 1'b0;
        for (int k = 0; k < fbc_pkg::NUM_PLANES; k++)
        begin
            row = k / fbc_pkg::PLANES_PER_ROW;
            for (int j = 0; j < fbc_pkg::MATRIX_DIM; j++)
            begin
                if (k % fbc_pkg::PLANES_PER_ROW != 0)
                    plane[j] = clip_entry(fbc_pkg::MATRIX_DIM - 1, j) - clip_entry(row, j);
                else
                    plane[j] = clip_entry(fbc_pkg::MATRIX_DIM - 1, j) + clip_entry(row, j);
            end
            // offset Q.16 to Q.24 to line up with normal * Q.8 coordinate
            plane_dist = plane[fbc_pkg::MATRIX_DIM-1] * (longint'(1) << fbc_pkg::OFFSET_SHIFT);
            reach      = 0;
            for (int j = 0; j < fbc_pkg::NUM_AXES; j++)
            begin
                plane_dist += plane[j] * ctr[j];
                reach      += ((plane[j] < 0) ? -plane[j] : plane[j]) * ext[j];
            end
            if (plane_dist + reach < 0)
                return fbc_pkg::VERDICT_OUTSIDE;
            if (plane_dist - reach < 0)
                partial = 1'b1;
        end
        return partial ? fbc_pkg::VERDICT_PARTIAL : fbc_pkg::VERDICT_INSIDE;
    endfunction

    function automatic int rand_around(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // APB write: setup, access, mirror updated on the access edge
    task automatic apb_write(int idx, cfg_word_t word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= paddr_t'(idx << fbc_pkg::CFG_IDX_LSB);
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        clip_regs[idx] = word;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Fill the working matrix for one setting
    task automatic build_matrix(mat_kind_t kind);
        for (int r = 0; r < fbc_pkg::MATRIX_DIM; r++)
        begin
            for (int c = 0; c < fbc_pkg::MATRIX_DIM; c++)
            begin
                case (kind)
                    MAT_ZERO:     mat_q[r][c] = 0;
                    MAT_UNIT:     mat_q[r][c] = (r == c) ? ONE : 0;
                    MAT_MAX_MIN:  mat_q[r][c] = (r % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    MAT_ALL_ONES: mat_q[r][c] = -1;
                    MAT_NOISE:    mat_q[r][c] = $urandom;
                    MAT_FRUSTUM:
                    begin
                        if (r == c && r < fbc_pkg::MATRIX_DIM - 1)
                        begin
                            mat_q[r][c] = $urandom_range(1 << 12, 1 << 18);
                            if ($urandom_range(0, 7) == 0)
                                mat_q[r][c] = -mat_q[r][c];
                        end
                        else if (r == fbc_pkg::MATRIX_DIM - 1 && c == fbc_pkg::MATRIX_DIM - 1)
                            mat_q[r][c] = ONE * $urandom_range(1, 4);
                        else if ($urandom_range(0, 2) == 0)
                            mat_q[r][c] = 0;    // zero normal component
                        else
                            mat_q[r][c] = rand_around(1 << 14);
                    end
                    default:      mat_q[r][c] = 0;
                endcase
            end
        end
        // fixed skewed setting: y has no weight in any plane
        if (kind == MAT_SKEW)
            mat_q = '{'{ONE + ONE / 2, 0, 0, 0},
                      '{0, 0, 0, 0},
                      '{0, 0, 2 * ONE, -ONE / 2},
                      '{0, 0, ONE, ONE}};
    endtask

    task automatic load_matrix();
        for (int c = 0; c < fbc_pkg::MATRIX_DIM; c++)
            for (int h = 0; h < fbc_pkg::CFG_ROWS_PER_REG; h++)
                apb_write(c * fbc_pkg::CFG_ROWS_PER_REG + h,
                          {mat_q[fbc_pkg::CFG_ROWS_PER_REG*h+1][c],
                           mat_q[fbc_pkg::CFG_ROWS_PER_REG*h][c]});
    endtask

    // Stop offering and let every outstanding verdict drain
    task automatic wait_idle();
        box_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Offer one box, hold it until the transfer, then maybe open a gap
    task automatic send_box(coord_t cx, coord_t cy, coord_t cz,
                            extent_t hx, extent_t hy, extent_t hz,
                            bit known, fbc_pkg::verdict_t want);
        box_valid <= 1'b1;
        center_x  <= cx;
        center_y  <= cy;
        center_z  <= cz;
        half_x    <= hx;
        half_y    <= hy;
        half_z    <= hz;
        @(posedge clk);
        while (!box_ready)
            @(posedge clk);
        pending_verdicts.push_back(known ? want : classify_box(cx, cy, cz, hx, hy, hz));
        burst_left--;
        if (burst_left <= 0)
        begin
            box_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 30);
        end
    endtask

    // Verdict sink: own stall pattern, plus a long hold-off on request
    initial
    begin : verdict_sink
        sink_mode_t mode;
        int         mode_left;
        mode      = SINK_OPEN;
        mode_left = 64;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served  = holds_served + 1;
                verdict_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   verdict_ready <= 1'b1;
                    SINK_COIN:   verdict_ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: verdict_ready <= ($urandom_range(0, 3) == 0);
                    default:     verdict_ready <= ~verdict_ready;
                endcase
            end
        end
    end

    // Compare each verdict transfer with the oldest prediction
    always @(posedge clk)
    begin : verdict_check
        fbc_pkg::verdict_t want;
        if (rst_n && verdict_valid && verdict_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("verdict: unexpected transfer, got %0d", verdict);
                error_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (verdict !== want)
                begin
                    $error("verdict: expected %0d, got %0d", want, verdict);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence
    initial
    begin : main_seq
        coord_t    cx, cy, cz;
        extent_t   hx, hy, hz;
        int        span;
        mat_kind_t loaded;

        for (int i = 0; i < fbc_pkg::CFG_NUM_REGS; i++)
            clip_regs[i] = '0;
        loaded = MAT_ZERO;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, matrix reloaded whenever the row asks for another
        foreach (directed[i])
        begin
            if (directed[i].mat != loaded)
            begin
                wait_idle();
                build_matrix(directed[i].mat);
                load_matrix();
                loaded = directed[i].mat;
            end
            send_box(directed[i].cx, directed[i].cy, directed[i].cz,
                     directed[i].hx, directed[i].hy, directed[i].hz,
                     directed[i].known, directed[i].want);
        end

        // random phases, each under a fresh matrix
        foreach (random_kinds[p])
        begin
            wait_idle();
            build_matrix(random_kinds[p]);
            load_matrix();
            if (p == 1)
            begin
                // sink holds off while a long burst fills the pipeline
                hold_requests <= hold_requests + 1;
                burst_left = 400;
            end
            for (int n = 0; n < random_counts[p]; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    cx = coord_t'($urandom);   cy = coord_t'($urandom);
                    cz = coord_t'($urandom);
                    hx = extent_t'($urandom);  hy = extent_t'($urandom);
                    hz = extent_t'($urandom);
                end
                else
                begin
                    span = 32'h40 << (2 * $urandom_range(0, 5));
                    cx = coord_t'(rand_around(2 * span));
                    cy = coord_t'(rand_around(2 * span));
                    cz = coord_t'(rand_around(2 * span));
                    hx = extent_t'($urandom_range(0, span));
                    hy = extent_t'($urandom_range(0, span));
                    hz = extent_t'($urandom_range(0, span));
                end
                send_box(cx, cy, cz, hx, hy, hz, 1'b0, fbc_pkg::VERDICT_INSIDE);
            end
        end

        wait_idle();
        repeat (DRAIN)
            @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
